// ===== sv/main_variable_exponent_split_macros.svh =====
`ifndef MAIN_VARIABLE_EXPONENT_SPLIT_MACROS_SVH
`define MAIN_VARIABLE_EXPONENT_SPLIT_MACROS_SVH

// Checks that a condition holds in the same cycle as its trigger.
`define MVES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that a condition holds in the cycle after its trigger.
`define MVES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mves_pkg.sv =====
`default_nettype none

package mves_pkg;

	// Input item kinds.
	localparam logic KIND_TERM = 1'b0;
	localparam logic KIND_END  = 1'b1;

	// Result kinds.
	localparam logic RK_INDEX  = 1'b0;
	localparam logic RK_REMAIN = 1'b1;

	// Configuration register indexes.
	localparam logic [2:0] REG_ORDER_MODE   = 3'd0;
	localparam logic [2:0] REG_FIELD_BITS   = 3'd1;
	localparam logic [2:0] REG_NUM_FIELDS   = 3'd2;
	localparam logic [2:0] REG_TOP_LIMIT    = 3'd3;
	localparam logic [2:0] REG_RADIX_ZERO   = 3'd4;
	localparam logic [2:0] REG_RADIX_ONE    = 3'd5;
	localparam logic [2:0] REG_RADIX_TWO    = 3'd6;
	localparam logic [2:0] REG_DEGREE_RADIX = 3'd7;

	typedef struct packed {
		logic        kind;
		logic [63:0] exponent_word;
	} item_t;

	typedef struct packed {
		logic        result_kind;
		logic [5:0]  slot;
		logic [63:0] value;
		logic        last;
	} result_t;

	typedef struct packed {
		logic        order_mode;
		logic [5:0]  field_bits;
		logic [2:0]  num_fields;
		logic [5:0]  top_limit;
		logic [63:0] radix_zero;
		logic [63:0] radix_one;
		logic [63:0] radix_two;
		logic [63:0] degree_radix;
	} cfg_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic        is_end;
		logic        mode;
		logic [3:0]  nf;
		logic [5:0]  first_slot;
		logic [6:0]  count;
		logic [63:0] term_no;
	} cmd_ctl_t;

	// Handshake and status signals of the back end.
	typedef struct packed {
		logic cmd_pop;
		logic out_push;
		logic idle;
	} bk_stat_t;

endpackage

`default_nettype wire

// ===== sv/mves_fifo.sv =====
`default_nettype none

module mves_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] rdata,
	output logic             empty
);
	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_q;
	logic [PW-1:0]    rd_q;
	logic [CW-1:0]    cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CW'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mves_front.sv =====
`default_nettype none

module mves_front #(
	parameter int MAX_FIELDS      = 4,
	parameter int TERM_INDEX_BITS = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          accept,
	input  mves_pkg::item_t               item,
	input  mves_pkg::cfg_t                cfg,
	output mves_pkg::cmd_ctl_t            ctl,
	output logic [MAX_FIELDS-1:0][63:0]   fields,
	output logic [5:0]                    next_slot
);
	import mves_pkg::*;

	logic [5:0]                 next_slot_q;
	logic [TERM_INDEX_BITS-1:0] term_count_q;
	logic [3:0]                 nf_eff;
	logic [8:0]                 top_amt;
	logic [63:0]                mask;
	logic [63:0]                top;
	logic                       top_lt;
	logic [5:0]                 lim;
	logic                       has_run;
	logic                       is_end;

	function automatic logic [63:0] shr64(input logic [63:0] v, input logic [8:0] amt);
		return (amt >= 9'd64) ? 64'd0 : (v >> amt[5:0]);
	endfunction

	assign nf_eff  = ({1'b0, cfg.num_fields} > 4'(MAX_FIELDS)) ? 4'(MAX_FIELDS)
	                                                         : {1'b0, cfg.num_fields};
	assign top_amt = 9'(cfg.field_bits) * 9'(nf_eff);
	assign mask    = (cfg.field_bits == 6'd0) ? 64'd0
	                                          : (~64'd0 >> (7'd64 - {1'b0, cfg.field_bits}));
	assign top     = shr64(item.exponent_word, top_amt);
	assign top_lt  = top < {58'd0, cfg.top_limit};
	assign lim     = cfg.top_limit - top[5:0];
	assign has_run = top_lt && (lim > next_slot_q);
	assign is_end  = (item.kind == KIND_END);

	for (genvar j = 0; j < MAX_FIELDS; j++) begin : g_field
		assign fields[j] = shr64(item.exponent_word, 9'(j) * 9'(cfg.field_bits)) & mask;
	end

	always_comb begin
		ctl.is_end     = is_end;
		ctl.mode       = cfg.order_mode;
		ctl.nf         = nf_eff;
		ctl.first_slot = next_slot_q;
		ctl.term_no    = 64'(term_count_q);
		if (is_end) begin
			ctl.count = ({1'b0, cfg.top_limit} >= {1'b0, next_slot_q})
			          ? ({1'b0, cfg.top_limit} - {1'b0, next_slot_q} + 7'd1) : 7'd0;
		end else begin
			ctl.count = has_run ? {1'b0, lim - next_slot_q} : 7'd0;
		end
	end

	assign next_slot = next_slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			next_slot_q  <= '0;
			term_count_q <= '0;
		end else if (accept) begin
			if (is_end) begin
				next_slot_q  <= '0;
				term_count_q <= '0;
			end else begin
				if (has_run) begin
					next_slot_q <= lim;
				end
				term_count_q <= term_count_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/mves_back.sv =====
`default_nettype none

module mves_back #(
	parameter int MAX_FIELDS = 4
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  mves_pkg::cfg_t              cfg,
	input  mves_pkg::cmd_ctl_t          ctl,
	input  logic [MAX_FIELDS-1:0][63:0] fields,
	input  logic                        cmd_empty,
	input  logic                        out_full,
	output mves_pkg::bk_stat_t          stat,
	output mves_pkg::result_t           out_word
);
	import mves_pkg::*;

	localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;

	typedef enum logic [7:0] {
		S_IDLE      = 8'b0000_0001,
		S_INDEX     = 8'b0000_0010,
		S_FOLD_INIT = 8'b0000_0100,
		S_FOLD_CHK  = 8'b0000_1000,
		S_MUL_LL    = 8'b0001_0000,
		S_MUL_LH    = 8'b0010_0000,
		S_MUL_HL    = 8'b0100_0000,
		S_EMIT      = 8'b1000_0000
	} state_t;

	state_t        state_q;
	logic [5:0]    slot_q;
	logic [6:0]    cnt_q;
	logic [63:0]   e_q;
	logic [63:0]   acc_q;
	logic [FW-1:0] j_q;
	logic [31:0]   jx;
	logic [63:0]   radix;
	logic [31:0]   op_a;
	logic [31:0]   op_b;
	logic [63:0]   prod;
	logic          run_done;

	assign jx = 32'(j_q);

	always_comb begin
		if (ctl.mode) begin
			radix = cfg.degree_radix;
		end else if (jx == 32'd0) begin
			radix = cfg.radix_zero;
		end else if (jx == 32'd1) begin
			radix = cfg.radix_one;
		end else if (jx == 32'd2) begin
			radix = cfg.radix_two;
		end else begin
			radix = 64'd1;
		end
	end

	// One 32x32 multiplier handles the three partial products of each step.
	always_comb begin
		op_a = e_q[31:0];
		op_b = radix[31:0];
		if (state_q == S_MUL_LH) begin
			op_b = radix[63:32];
		end else if (state_q == S_MUL_HL) begin
			op_a = e_q[63:32];
		end
	end

	assign prod     = 64'(op_a) * 64'(op_b);
	assign run_done = (cnt_q == 7'd1);

	always_comb begin
		stat.idle     = (state_q == S_IDLE);
		stat.out_push = ((state_q == S_INDEX) || (state_q == S_EMIT)) && !out_full;
		stat.cmd_pop  = ((state_q == S_IDLE) && !cmd_empty && ctl.is_end && (ctl.count == 7'd0))
		             || ((state_q == S_INDEX) && !out_full && run_done && ctl.is_end)
		             || ((state_q == S_EMIT) && !out_full);
		if (state_q == S_INDEX) begin
			out_word.result_kind = RK_INDEX;
			out_word.slot        = slot_q;
			out_word.value       = ctl.term_no;
			out_word.last        = ctl.is_end && run_done;
		end else begin
			out_word.result_kind = RK_REMAIN;
			out_word.slot        = 6'd0;
			out_word.value       = e_q;
			out_word.last        = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			slot_q  <= '0;
			cnt_q   <= '0;
			e_q     <= '0;
			acc_q   <= '0;
			j_q     <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (!cmd_empty) begin
						slot_q <= ctl.first_slot;
						cnt_q  <= ctl.count;
						if (ctl.count != 7'd0) begin
							state_q <= S_INDEX;
						end else if (!ctl.is_end) begin
							state_q <= S_FOLD_INIT;
						end
					end
				end
				S_INDEX: begin
					if (!out_full) begin
						slot_q <= slot_q + 1'b1;
						cnt_q  <= cnt_q - 1'b1;
						if (run_done) begin
							state_q <= ctl.is_end ? S_IDLE : S_FOLD_INIT;
						end
					end
				end
				S_FOLD_INIT: begin
					if (ctl.nf > {3'd0, ctl.mode}) begin
						e_q     <= fields[FW'(ctl.nf - 4'd1)];
						j_q     <= FW'(ctl.nf - 4'd1);
						state_q <= S_FOLD_CHK;
					end else begin
						e_q     <= 64'd0;
						state_q <= S_EMIT;
					end
				end
				S_FOLD_CHK: begin
					if (jx > 32'(ctl.mode)) begin
						j_q     <= j_q - 1'b1;
						state_q <= S_MUL_LL;
					end else begin
						state_q <= S_EMIT;
					end
				end
				S_MUL_LL: begin
					acc_q   <= prod + fields[j_q];
					state_q <= S_MUL_LH;
				end
				S_MUL_LH: begin
					acc_q   <= acc_q + {prod[31:0], 32'd0};
					state_q <= S_MUL_HL;
				end
				S_MUL_HL: begin
					e_q     <= acc_q + {prod[31:0], 32'd0};
					state_q <= S_FOLD_CHK;
				end
				S_EMIT: begin
					if (!out_full) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== sv/main_variable_exponent_split.sv =====
// Channel   Direction  Handshake                Word
// item      in         push / full              kind, exponent_word
// result    out        empty / pop              result_kind, slot, value, last
// cfg       in         cfg_valid / cfg_ready    cfg_index, cfg_data
//
// A term writes n index entries in the back end, one per cycle while the result queue
// has room, then runs k fold steps after the top field, each three passes through the shared
// 32x32 multiplier plus a check. An end item writes only its n index entries. The front
// classifies one word per cycle while full is low. Reset is asynchronous and active low;
// it clears the queues and the slot and term counters and restores the register
// defaults. A full result queue holds the back end, and a full command queue raises full.
`default_nettype none

`include "main_variable_exponent_split_macros.svh"

module main_variable_exponent_split #(
	parameter int MAX_FIELDS      = 4,
	parameter int TERM_INDEX_BITS = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  mves_pkg::item_t   item,
	output logic              empty,
	input  logic              pop,
	output mves_pkg::result_t result,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [2:0]        cfg_index,
	input  logic [63:0]       cfg_data
);
	import mves_pkg::*;

	localparam int CMD_W = $bits(cmd_ctl_t) + MAX_FIELDS * 64;
	localparam int RES_W = $bits(result_t);

	cfg_t                        cfg_q;
	logic                        accept;
	cmd_ctl_t                    fr_ctl;
	logic [MAX_FIELDS-1:0][63:0] fr_fields;
	logic [5:0]                  front_slot;
	logic                        cmd_empty;
	logic [CMD_W-1:0]            cmd_rdata;
	cmd_ctl_t                    hd_ctl;
	logic [MAX_FIELDS-1:0][63:0] hd_fields;
	bk_stat_t                    bk_stat;
	result_t                     bk_word;
	logic                        out_full;
	logic [RES_W-1:0]            out_rdata;

	// Registers are always writable; software must write them only while the block is idle.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.order_mode   <= 1'b0;
			cfg_q.field_bits   <= 6'd8;
			cfg_q.num_fields   <= 3'd1;
			cfg_q.top_limit    <= 6'd0;
			cfg_q.radix_zero   <= 64'd1;
			cfg_q.radix_one    <= 64'd1;
			cfg_q.radix_two    <= 64'd1;
			cfg_q.degree_radix <= 64'd1;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ORDER_MODE:   cfg_q.order_mode   <= cfg_data[0];
				REG_FIELD_BITS:   cfg_q.field_bits   <= cfg_data[5:0];
				REG_NUM_FIELDS:   cfg_q.num_fields   <= cfg_data[2:0];
				REG_TOP_LIMIT:    cfg_q.top_limit    <= cfg_data[5:0];
				REG_RADIX_ZERO:   cfg_q.radix_zero   <= cfg_data;
				REG_RADIX_ONE:    cfg_q.radix_one    <= cfg_data;
				REG_RADIX_TWO:    cfg_q.radix_two    <= cfg_data;
				REG_DEGREE_RADIX: cfg_q.degree_radix <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front tracks the slot and term counters itself, so each command leaving it
	// already says which slots to fill and with which term number.
	assign accept = push && !full;

	mves_front #(
		.MAX_FIELDS      (MAX_FIELDS),
		.TERM_INDEX_BITS (TERM_INDEX_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.item      (item),
		.cfg       (cfg_q),
		.ctl       (fr_ctl),
		.fields    (fr_fields),
		.next_slot (front_slot)
	);

	// The command at the head of this queue stays put until the back end has
	// delivered its last word, so the back end reads it in place.
	mves_fifo #(
		.WIDTH (CMD_W),
		.DEPTH (2)
	) u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (accept),
		.wdata  ({fr_ctl, fr_fields}),
		.full   (full),
		.pop    (bk_stat.cmd_pop),
		.rdata  (cmd_rdata),
		.empty  (cmd_empty)
	);

	assign {hd_ctl, hd_fields} = cmd_rdata;

	mves_back #(
		.MAX_FIELDS (MAX_FIELDS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.ctl       (hd_ctl),
		.fields    (hd_fields),
		.cmd_empty (cmd_empty),
		.out_full  (out_full),
		.stat      (bk_stat),
		.out_word  (bk_word)
	);

	// The result queue parts the back end from the consumer.
	mves_fifo #(
		.WIDTH (RES_W),
		.DEPTH (2)
	) u_out_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (bk_stat.out_push),
		.wdata  (bk_word),
		.full   (out_full),
		.pop    (pop),
		.rdata  (out_rdata),
		.empty  (empty)
	);

	assign result = result_t'(out_rdata);

	`MVES_ASSERT_NOW(a_out_space, bk_stat.out_push, !out_full, "word pushed into a full result queue")
	`MVES_ASSERT_NOW(a_cmd_head, bk_stat.cmd_pop, !cmd_empty, "command retired from an empty queue")
	`MVES_ASSERT_NOW(a_idle_quiet, bk_stat.idle, !bk_stat.out_push, "idle back end pushed a word")
	`MVES_ASSERT_NEXT(a_end_clears, accept && (item.kind == KIND_END), front_slot == 6'd0, "end word left a slot pending")

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;

	import mves_pkg::*;

	// Block parameters, kept at the values the block is built with.
	localparam int MAX_FIELDS      = 4;
	localparam int TERM_INDEX_BITS = 32;

	// Ample time for the back end to finish a term's index entries and fold steps,
	// so that the block goes quiet.
	localparam int SETTLE_CYCLES = 200;

	// Timeout in ns at a 20 ns clock period; a correct run needs a small part of it.
	localparam longint RUN_LIMIT_NS = 64'd20_000_000;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        push      = 1'b0;
	logic        full;
	item_t       item      = '0;
	logic        empty;
	logic        pop       = 1'b0;
	result_t     result;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [2:0]  cfg_index = '0;
	logic [63:0] cfg_data  = '0;

	main_variable_exponent_split #(
		.MAX_FIELDS     (MAX_FIELDS),
		.TERM_INDEX_BITS(TERM_INDEX_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.empty    (empty),
		.pop      (pop),
		.result   (result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	always #10 clk = ~clk;

	// Our own copy of the register file and of the splitter state.
	cfg_t                       model_cfg;
	logic [5:0]                 slot_next;
	logic [TERM_INDEX_BITS-1:0] terms_seen;

	// Result words still owed by the block, oldest first.
	result_t owed_results[$];

	// Percentages for random idling on the input side and stalling on the output side.
	int idle_pct  = 0;
	int stall_pct = 0;
	logic hold_off = 1'b0;

	int mismatches  = 0;
	int words_in    = 0;
	int words_out   = 0;
	int reg_writes  = 0;
	int full_stalls = 0;

	result_t due;

	// Logical right shift where any distance of 64 or more clears the word.
	function automatic logic [63:0] shift_down(input logic [63:0] v, input int n);
		return (n >= 64) ? 64'd0 : (v >> n);
	endfunction

	// Number of packed fields actually used; larger settings are clamped.
	function automatic int fields_used();
		return (int'(model_cfg.num_fields) > MAX_FIELDS) ? MAX_FIELDS
			: int'(model_cfg.num_fields);
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Computes every result word that one accepted input word causes and advances
	// the slot pointer and the term counter the way the block does.
	task automatic split_exponent(input item_t w);
		int s, tl, fb, nf, lim, j;
		logic [63:0] mask, top, fold, rdx;
		result_t r;
		s  = int'(slot_next);
		tl = int'(model_cfg.top_limit);
		fb = int'(model_cfg.field_bits);
		nf = fields_used();
		r  = '0;
		if (w.kind == KIND_END) begin
			// Flush: every slot left up to the top limit gets the term count.
			while (s <= tl) begin
				r.result_kind = RK_INDEX;
				r.slot        = s[5:0];
				r.value       = 64'(terms_seen);
				r.last        = (s == tl);
				owed_results.push_back(r);
				s++;
			end
			slot_next  = '0;
			terms_seen = '0;
		end else begin
			mask = (fb == 0) ? 64'd0 : (~64'd0 >> (64 - fb));
			top  = shift_down(w.exponent_word, fb * nf);
			// Slots below top_limit - top point at this term; a high exponent writes none.
			if (top < 64'(tl)) begin
				lim = tl - int'(top);
				while (s < lim) begin
					r.result_kind = RK_INDEX;
					r.slot        = s[5:0];
					r.value       = 64'(terms_seen);
					r.last        = 1'b0;
					owed_results.push_back(r);
					s++;
				end
			end
			// Horner fold from the highest field down; degree order leaves out field zero.
			fold = '0;
			for (j = nf; j > int'(model_cfg.order_mode); j--) begin
				if (model_cfg.order_mode) begin
					rdx = model_cfg.degree_radix;
				end else begin
					case (j - 1)
						0: rdx = model_cfg.radix_zero;
						1: rdx = model_cfg.radix_one;
						2: rdx = model_cfg.radix_two;
						default: rdx = 64'd1;
					endcase
				end
				fold = fold * rdx + (shift_down(w.exponent_word, (j - 1) * fb) & mask);
			end
			r.result_kind = RK_REMAIN;
			r.slot        = '0;
			r.value       = fold;
			r.last        = 1'b1;
			owed_results.push_back(r);
			slot_next  = s[5:0];
			terms_seen = terms_seen + 1'b1;
		end
	endtask

	// Offers one word on the input queue, idling first at random, and keeps push
	// high on return so that a following word can go out back to back.
	task automatic send_word(input item_t w);
		while ($urandom_range(99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		item <= w;
		do @(posedge clk); while (full);
		split_exponent(w);
		words_in++;
	endtask

	task automatic send_term(input logic [63:0] word);
		item_t w;
		w.kind          = KIND_TERM;
		w.exponent_word = word;
		send_word(w);
	endtask

	// The exponent word of an end item is ignored, so it carries random bits.
	task automatic send_end();
		item_t w;
		w.kind          = KIND_END;
		w.exponent_word = random_word();
		send_word(w);
	endtask

	// Places a main-variable exponent above random lower fields.
	function automatic logic [63:0] pack_top(input int top);
		int sh;
		logic [63:0] low;
		sh  = int'(model_cfg.field_bits) * fields_used();
		low = random_word();
		if (sh >= 64)
			return low;
		return (low & ((64'd1 << sh) - 64'd1)) | (64'(top) << sh);
	endfunction

	// A well formed polynomial: terms with main exponents that never rise, then an end.
	task automatic send_poly(input int n_terms);
		int top;
		top = $urandom_range(int'(model_cfg.top_limit) + 3);
		repeat (n_terms) begin
			send_term(pack_top(top));
			top = $urandom_range(top);
		end
		send_end();
	endtask

	// Stops offering words and waits until every owed result has come out, then
	// gives the block time to finish work that causes no result.
	task automatic settle();
		push <= 1'b0;
		while (owed_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_valid high so that writes go out back to back.
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		reg_writes++;
	endtask

	// Writes the whole register file once the block is quiet.
	task automatic configure(input cfg_t c);
		settle();
		write_reg(REG_ORDER_MODE, 64'(c.order_mode));
		write_reg(REG_FIELD_BITS, 64'(c.field_bits));
		write_reg(REG_NUM_FIELDS, 64'(c.num_fields));
		write_reg(REG_TOP_LIMIT, 64'(c.top_limit));
		write_reg(REG_RADIX_ZERO, c.radix_zero);
		write_reg(REG_RADIX_ONE, c.radix_one);
		write_reg(REG_RADIX_TWO, c.radix_two);
		write_reg(REG_DEGREE_RADIX, c.degree_radix);
		cfg_valid <= 1'b0;
		model_cfg = c;
	endtask

	function automatic logic [63:0] pick_radix();
		case ($urandom_range(4))
			0: return 64'd0;
			1: return 64'd1;
			2: return ~64'd0;
			3: return 64'($urandom_range(2, 1000));
			default: return random_word();
		endcase
	endfunction

	// Random settings, leaning on the edges of each register's range.
	function automatic cfg_t pick_config();
		cfg_t c;
		c.order_mode = 1'($urandom_range(1));
		case ($urandom_range(5))
			0: c.field_bits = 6'd0;
			1: c.field_bits = 6'd1;
			2: c.field_bits = 6'd32;
			3: c.field_bits = 6'd63;
			default: c.field_bits = 6'($urandom_range(2, 16));
		endcase
		c.num_fields   = ($urandom_range(4) == 0) ? 3'($urandom_range(7))
			: 3'($urandom_range(1, 4));
		c.top_limit    = 6'($urandom_range(63));
		c.radix_zero   = pick_radix();
		c.radix_one    = pick_radix();
		c.radix_two    = pick_radix();
		c.degree_radix = pick_radix();
		return c;
	endfunction

	task automatic hold_results(input int cycles);
		hold_off <= 1'b1;
		repeat (cycles) @(posedge clk);
		hold_off <= 1'b0;
	endtask

	// Output side: pop at random unless a long hold-off is in force.
	always @(posedge clk)
		pop <= !hold_off && ($urandom_range(99) >= stall_pct);

	// Every word taken off the result queue is checked against the oldest one owed.
	always @(posedge clk) begin
		if (arst_n && push && full)
			full_stalls++;
		if (arst_n && pop && !empty) begin
			words_out++;
			if (owed_results.size() == 0) begin
				$display("%0t: unexpected word, expected none, got %p", $time, result);
				mismatches++;
			end else begin
				due = owed_results.pop_front();
				if (result.result_kind !== due.result_kind) begin
					$display("%0t: result_kind expected %0d got %0d", $time,
						due.result_kind, result.result_kind);
					mismatches++;
				end
				if (result.slot !== due.slot) begin
					$display("%0t: slot expected %0d got %0d", $time, due.slot, result.slot);
					mismatches++;
				end
				if (result.value !== due.value) begin
					$display("%0t: value expected %h got %h", $time, due.value, result.value);
					mismatches++;
				end
				if (result.last !== due.last) begin
					$display("%0t: last expected %0d got %0d", $time, due.last, result.last);
					mismatches++;
				end
			end
		end
	end

	// Right after reset the default registers apply: one field of eight bits under
	// the main exponent and a top limit of zero, so only slot zero exists.
	task automatic test_reset_defaults();
		send_term(64'h0105);
		send_term(~64'd0);
		send_end();
	endtask

	// Fold corner cases: extreme radices in both orders, a zero field width, field
	// shifts of 64 bits or more, too many fields, and no fields at all.
	task automatic test_fold_extremes();
		cfg_t c;
		c.order_mode   = 1'b0;
		c.field_bits   = 6'd8;
		c.num_fields   = 3'd4;
		c.top_limit    = 6'd10;
		c.radix_zero   = ~64'd0;
		c.radix_one    = random_word();
		c.radix_two    = random_word();
		c.degree_radix = 64'd0;
		configure(c);
		send_term(~64'd0);
		send_term(64'd0);
		send_term(random_word());

		c.order_mode   = 1'b1;
		c.field_bits   = 6'd16;
		c.radix_zero   = 64'd0;
		c.radix_one    = 64'd0;
		c.radix_two    = 64'd0;
		c.degree_radix = ~64'd0;
		configure(c);
		send_term(random_word());
		send_term(~64'd0);

		// Zero field width: every field reads as zero.
		c.field_bits   = 6'd0;
		c.num_fields   = 3'd2;
		c.degree_radix = random_word();
		configure(c);
		send_term(random_word());

		// The main exponent sits 80 bits up and reads as zero.
		c.order_mode = 1'b0;
		c.field_bits = 6'd40;
		c.radix_zero = random_word();
		c.radix_one  = random_word();
		configure(c);
		send_term(random_word());

		// Seven fields are clamped to four, half of them shifted out of the word.
		c.field_bits = 6'd63;
		c.num_fields = 3'd7;
		c.radix_two  = random_word();
		configure(c);
		send_term(random_word());

		// With no fields the whole word is the main exponent and the fold is zero.
		c.field_bits = 6'd32;
		c.num_fields = 3'd0;
		c.top_limit  = 6'd62;
		configure(c);
		send_term(random_word());
		send_term(64'd3);
		send_end();

		// Degree order with a single field has nothing left to fold.
		c.order_mode = 1'b1;
		c.num_fields = 3'd1;
		configure(c);
		send_term(random_word());
	endtask

	// Index table edges: a term whose exponent is too high, a flush with no slot
	// left after the limit is lowered, and the 63 limit with its 64-entry flush.
	task automatic test_index_edges();
		cfg_t c;
		c.order_mode   = 1'b0;
		c.field_bits   = 6'd8;
		c.num_fields   = 3'd1;
		c.top_limit    = 6'd20;
		c.radix_zero   = 64'd1;
		c.radix_one    = 64'd1;
		c.radix_two    = 64'd1;
		c.degree_radix = 64'd1;
		configure(c);
		send_term({48'd0, 8'd25, 8'h33});
		send_term(64'h44);

		c.top_limit = 6'd5;
		configure(c);
		send_end();
		send_end();

		c.top_limit = 6'd63;
		configure(c);
		send_term(64'h01);
		send_end();
		send_end();
	endtask

	// Random polynomials with some stray words mixed in, under four idling patterns.
	task automatic test_random_polys();
		int phase, start;
		item_t w;
		for (phase = 0; phase < 4; phase++) begin
			configure(pick_config());
			idle_pct  = (phase == 1) ? 64 : (phase == 3) ? 21 : 0;
			stall_pct = (phase == 2) ? 64 : (phase == 3) ? 21 : 0;
			start = words_in;
			while (words_in - start < 22) begin
				if ($urandom_range(4) == 0) begin
					w.kind          = 1'($urandom_range(1));
					w.exponent_word = random_word();
					send_word(w);
				end else begin
					send_poly($urandom_range(1, 6));
				end
			end
		end
	endtask

	// The output side holds off for a long stretch while words keep coming, so the
	// block backs up until it refuses input.
	task automatic test_backpressure();
		cfg_t c;
		c = pick_config();
		c.field_bits = 6'd8;
		c.num_fields = 3'd2;
		c.top_limit  = 6'd40;
		configure(c);
		idle_pct  = 0;
		stall_pct = 0;
		fork
			hold_results(600);
			repeat (4) send_poly(8);
		join
	endtask

	initial begin
		model_cfg.order_mode   = 1'b0;
		model_cfg.field_bits   = 6'd8;
		model_cfg.num_fields   = 3'd1;
		model_cfg.top_limit    = 6'd0;
		model_cfg.radix_zero   = 64'd1;
		model_cfg.radix_one    = 64'd1;
		model_cfg.radix_two    = 64'd1;
		model_cfg.degree_radix = 64'd1;
		slot_next  = '0;
		terms_seen = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_fold_extremes();
		test_index_edges();
		test_random_polys();
		test_backpressure();
		settle();

		$display("Sent %0d words and checked %0d result words over %0d register writes.",
			words_in, words_out, reg_writes);
		$display("Input was refused on %0d cycles while the output side held back.",
			full_stalls);
		if (mismatches == 0) begin
			$display("tb OK");
		end else begin
			$display("tb NOT OK");
		end
		$finish;
	end

	// Safety net for a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("tb NOT OK");
		$finish;
	end

endmodule
